// ===== rtl/bfba_pkg.sv =====
// Shared types, codes and defaults for the bitmap free-bit allocator.
package bfba_pkg;

  localparam int WORDS_DEF = 64;
  localparam int WIU_W     = 7;
  localparam int IDX_W     = 11;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 2;
  localparam logic [WIU_W-1:0] WIU_RESET = 7'd64;

  localparam logic [REQ_W-1:0] REQ_FIND  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE_FREE = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;

  typedef struct packed {
    logic              latch_in;
    logic              ctr_clear;
    logic              ctr_inc;
    logic              clr_wr;
    logic              rmw_rd;
    logic              rmw_wr;
    logic              found_ld;
    logic              res_load;
    logic [STAT_W-1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic n_zero;
    logic word_full;
    logic scan_last;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/bfba_ctrl.sv =====
// Request sequencer: clearing pass, find scan, read-modify-write, result handoff.
module bfba_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bfba_pkg::REQ_W-1:0]     in_req_type,
  input  bfba_pkg::sts_t                 sts,
  output bfba_pkg::cmd_t                 cmd
);
  import bfba_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MRD  = 3'd3;
  localparam logic [2:0] S_MWR  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [STAT_W-1:0] pend_r, pend_nxt;
  logic              accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    cmd.res_status = pend_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr  = 1'b1;
        cmd.ctr_inc = 1'b1;
        if (sts.clr_last) begin
          cmd.ctr_inc   = 1'b0;
          cmd.ctr_clear = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.latch_in = 1'b1;
          case (in_req_type)
            REQ_FIND: begin
              if (sts.n_zero) begin
                pend_nxt  = ST_NONE_FREE;
                state_nxt = S_DONE;
              end else begin
                cmd.ctr_clear = 1'b1;
                state_nxt     = S_SCAN;
              end
            end
            REQ_SET, REQ_CLEAR: begin
              if (sts.in_range) begin
                state_nxt = S_MRD;
              end else begin
                pend_nxt  = ST_RANGE;
                state_nxt = S_DONE;
              end
            end
            default: begin
              pend_nxt  = ST_OK;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!sts.word_full) begin
          cmd.found_ld = 1'b1;
          pend_nxt     = ST_OK;
          state_nxt    = S_DONE;
        end else if (sts.scan_last) begin
          pend_nxt  = ST_NONE_FREE;
          state_nxt = S_DONE;
        end else begin
          cmd.ctr_inc = 1'b1;
        end
      end
      S_MRD: begin
        cmd.rmw_rd = 1'b1;
        state_nxt  = S_MWR;
      end
      S_MWR: begin
        cmd.rmw_wr = 1'b1;
        pend_nxt   = ST_OK;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      pend_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> state_r == S_CLR)
    else $error("clearing pass not started after reset");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> sts.out_free)
    else $error("result loaded over a pending item");
  a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && cmd.ctr_inc) |-> (sts.word_full && !sts.scan_last))
    else $error("scan advanced past a free word or the last word");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_wr, cmd.rmw_wr}))
    else $error("two memory writes in one cycle");

endmodule

// ===== rtl/bfba_dp.sv =====
// Bitmap memory, word counter, range checks and result register.
module bfba_dp #(
  parameter int WORDS = bfba_pkg::WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [bfba_pkg::WIU_W-1:0]     wiu,
  input  logic [bfba_pkg::REQ_W-1:0]     in_req_type,
  input  logic [bfba_pkg::IDX_W-1:0]     in_bit_index,
  input  bfba_pkg::cmd_t                 cmd,
  output bfba_pkg::sts_t                 sts,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bfba_pkg::STAT_W-1:0]    out_status,
  output logic [bfba_pkg::IDX_W-1:0]     out_free_index
);
  import bfba_pkg::*;

  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNT_W = (AW + 1 > WIU_W) ? AW + 1 : WIU_W;

  logic [31:0]       mem [WORDS];
  logic [31:0]       rd_data_r;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     ctr_r, ctr_nxt;
  logic [AW-1:0]     word_r;
  logic [4:0]        bit_r;
  logic              set_r;
  logic [IDX_W-1:0]  found_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [IDX_W-1:0]  out_index_r;
  logic [CNT_W-1:0]  n_act;
  logic [CNT_W-1:0]  in_word;
  logic [CNT_W+4:0]  found_w;
  logic [4:0]        zero_pos;
  logic              mem_we;
  logic [AW-1:0]     wr_addr;
  logic [31:0]       wr_data;
  logic [31:0]       bit_mask;

  assign n_act   = (CNT_W'(wiu) > CNT_W'(WORDS)) ? CNT_W'(WORDS) : CNT_W'(wiu);
  assign in_word = CNT_W'(in_bit_index[IDX_W-1:5]);

  always_comb begin
    zero_pos = 5'd31;
    for (int i = 31; i >= 0; i--) begin
      if (!rd_data_r[i]) begin
        zero_pos = 5'(i);
      end
    end
  end

  assign found_w = {CNT_W'(ctr_r), zero_pos};

  always_comb begin
    ctr_nxt = ctr_r;
    if (cmd.ctr_clear) begin
      ctr_nxt = '0;
    end else if (cmd.ctr_inc) begin
      ctr_nxt = ctr_r + AW'(1);
    end
  end

  assign rd_addr  = cmd.rmw_rd ? word_r : ctr_nxt;
  assign bit_mask = 32'd1 << bit_r;
  assign mem_we   = cmd.clr_wr | cmd.rmw_wr;
  assign wr_addr  = cmd.clr_wr ? ctr_r : word_r;
  assign wr_data  = cmd.clr_wr ? 32'd0 :
                    (set_r ? (rd_data_r | bit_mask) : (rd_data_r & ~bit_mask));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctr_r <= ctr_nxt;
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      word_r  <= in_word[AW-1:0];
      bit_r   <= in_bit_index[4:0];
      set_r   <= (in_req_type == REQ_SET);
      found_r <= '0;
    end else if (cmd.found_ld) begin
      found_r <= found_w[IDX_W-1:0];
    end
    if (cmd.res_load) begin
      out_status_r <= cmd.res_status;
      out_index_r  <= found_r;
    end
  end

  assign sts.in_range  = (in_word < n_act);
  assign sts.n_zero    = (n_act == '0);
  assign sts.word_full = &rd_data_r;
  assign sts.scan_last = ((CNT_W'(ctr_r) + CNT_W'(1)) == n_act);
  assign sts.clr_last  = (ctr_r == AW'(WORDS - 1));
  assign sts.out_free  = !out_valid_r | out_tready;

  assign out_tvalid     = out_valid_r;
  assign out_status     = out_status_r;
  assign out_free_index = out_index_r;

endmodule

// ===== rtl/bitmap_free_bit_allocator.sv =====
// Top level: stream ports, APB register and allocator controller/datapath.
// Find: scans from word 0, one word a cycle, until a free bit or the last word in use.
// Set/clear: read, modify-write, result load; out of range, none free, code 3: load only.
// One item at a time; in_tready returns the cycle after the result loads.
// Reset (sync, active low) clears all WORDS words in a pass, in_tready low meanwhile.
// words_in_use resets to 64; register writes are taken at any time.
module bitmap_free_bit_allocator #(
  parameter int WORDS = bfba_pkg::WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // bit_index[10:0], zeros
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // free_index[10:0], zeros
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bfba_pkg::*;

  logic [WIU_W-1:0]  wiu_r;
  cmd_t              cmd;
  sts_t              sts;
  logic [IDX_W-1:0]  free_index;
  logic [STAT_W-1:0] status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-WIU_W){1'b0}}, wiu_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wiu_r <= WIU_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      wiu_r <= pwdata[WIU_W-1:0];
    end
  end

  bfba_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_req_type (in_tuser),
    .sts         (sts),
    .cmd         (cmd)
  );

  bfba_dp #(
    .WORDS (WORDS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .wiu            (wiu_r),
    .in_req_type    (in_tuser),
    .in_bit_index   (in_tdata[IDX_W-1:0]),
    .cmd            (cmd),
    .sts            (sts),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_status     (status),
    .out_free_index (free_index)
  );

  assign out_tdata = {{(16-IDX_W){1'b0}}, free_index};
  assign out_tuser = status;

endmodule

// ===== tb/tb_bitmap_free_bit_allocator.sv =====
// Self-checking testbench for bitmap_free_bit_allocator: stream requests, APB setting, bitmap model.
module tb_bitmap_free_bit_allocator;
  import bfba_pkg::*;

  localparam int WORDS = WORDS_DEF;
  localparam logic [2:0] ADDR_WORDS_IN_USE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 104;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  free_index;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [31:0] map_words [WORDS];
    logic [WIU_W-1:0] words_cfg;
    alloc_result_t expected_q [$];
    int errors;

    function new();
      foreach (map_words[i]) map_words[i] = '0;
      words_cfg = WIU_RESET;
      errors = 0;
    endfunction

    function int active_words();
      return (int'(words_cfg) > WORDS) ? WORDS : int'(words_cfg);
    endfunction

    function alloc_result_t first_free();
      alloc_result_t r;
      int n;
      bit hit;
      n = active_words();
      hit = 1'b0;
      r.status = ST_NONE_FREE;
      r.free_index = '0;
      for (int w = 0; w < n && !hit; w++) begin
        for (int b = 0; b < 32 && !hit; b++) begin
          if (!map_words[w][b]) begin
            hit = 1'b1;
            r.status = ST_OK;
            r.free_index = IDX_W'(w * 32 + b);
          end
        end
      end
      return r;
    endfunction

    function void note_item(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx);
      alloc_result_t r;
      int word;
      r.status = ST_OK;
      r.free_index = '0;
      word = int'(idx[IDX_W-1:5]);
      if (req == REQ_FIND) begin
        r = first_free();
      end else if (req == REQ_SET || req == REQ_CLEAR) begin
        if (word >= active_words()) r.status = ST_RANGE;
        else map_words[word][idx[4:0]] = (req == REQ_SET);
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [STAT_W-1:0] status, logic [IDX_W-1:0] free_index);
      alloc_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected item: status %0d free_index %0d", status, free_index);
        return;
      end
      e = expected_q.pop_front();
      if (status !== e.status || free_index !== e.free_index) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: status exp %0d got %0d, free_index exp %0d got %0d",
                   e.status, status, e.free_index, free_index);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [15:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tready = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic in_tready;
  logic out_tvalid;
  logic [15:0] out_tdata;
  logic [1:0] out_tuser;
  logic [31:0] prdata;
  logic pready;

  int cycle_count = 0;
  int stall_left = 0;
  bit send_idle = 1'b0;
  bit take_idle = 1'b0;
  alloc_scoreboard board;

  bitmap_free_bit_allocator #(.WORDS(WORDS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bitmap_free_bit_allocator regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      board.check_result(out_tuser, out_tdata[IDX_W-1:0]);
      stall_left = take_idle ? $urandom_range(10, 0) : 0;
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx);
    int gap;
    gap = send_idle ? $urandom_range(10, 0) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {{(16 - IDX_W){1'b0}}, idx};
    do @(posedge clk); while (!in_tready);
    board.note_item(req, idx);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_words_in_use(input int val);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_WORDS_IN_USE;
    pwdata <= ($urandom() & ~32'h7F) | (val & 32'h7F);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.words_cfg = WIU_W'(val);
  endtask

  function automatic logic [IDX_W-1:0] pick_index(int lo_word, int hi_word);
    return IDX_W'($urandom_range(hi_word, lo_word) * 32 + $urandom_range(31, 0));
  endfunction

  task automatic run_phase(input int wiu, input int count);
    int sent;
    int n;
    int pick;
    alloc_result_t r;
    write_words_in_use(wiu);
    n = board.active_words();
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(29, 0) == 0) begin
        send_idle = ($urandom_range(3, 0) != 0);
        take_idle = ($urandom_range(3, 0) != 0);
      end
      if ($urandom_range(59, 0) == 0) drain();
      pick = $urandom_range(99, 0);
      if (pick < 40) begin
        // allocate: find, then mark the bit found
        r = board.first_free();
        send_item(REQ_FIND, IDX_W'($urandom_range(2047, 0)));
        sent++;
        if (r.status == ST_OK) begin
          send_item(REQ_SET, r.free_index);
          sent++;
        end
      end else if (pick < 52) begin
        if (n == 0) send_item(REQ_CLEAR, IDX_W'($urandom_range(2047, 0)));
        else if ($urandom_range(1, 0)) send_item(REQ_CLEAR, pick_index(0, (n < 2) ? 0 : 1));
        else send_item(REQ_CLEAR, pick_index(0, n - 1));
        sent++;
      end else if (pick < 60) begin
        send_item(REQ_FIND, IDX_W'($urandom_range(2047, 0)));
        sent++;
      end else if (pick < 72) begin
        send_item(REQ_SET, (n == 0) ? IDX_W'($urandom_range(2047, 0)) : pick_index(0, n - 1));
        sent++;
      end else if (pick < 82) begin
        send_item($urandom_range(1, 0) ? REQ_SET : REQ_CLEAR,
                  (n < WORDS) ? pick_index(n, WORDS - 1) : IDX_W'($urandom_range(2047, 0)));
        sent++;
      end else if (pick < 88) begin
        send_item(REQ_NOP, IDX_W'($urandom_range(2047, 0)));
        sent++;
      end else begin
        send_item(REQ_W'($urandom_range(3, 0)), IDX_W'($urandom_range(2047, 0)));
        sent++;
      end
    end
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // full map in use after reset
    send_item(REQ_FIND, 11'd2047);
    send_item(REQ_SET, 11'd0);
    send_item(REQ_FIND, 11'd0);
    send_item(REQ_SET, 11'd2047);
    send_item(REQ_SET, 11'd1);
    send_item(REQ_SET, 11'd2);
    send_item(REQ_CLEAR, 11'd1);
    send_item(REQ_FIND, 11'd0);
    send_item(REQ_CLEAR, 11'd2047);
    send_item(REQ_NOP, 11'd2047);
    send_item(REQ_NOP, 11'd0);
    send_item(REQ_SET, 11'd1055);
    send_item(REQ_CLEAR, 11'd0);
    send_item(REQ_FIND, 11'd1365);

    // no word in use
    write_words_in_use(0);
    send_item(REQ_FIND, 11'd0);
    send_item(REQ_SET, 11'd0);
    send_item(REQ_CLEAR, 11'd2047);

    // count above the map size clamps
    write_words_in_use(127);
    send_item(REQ_SET, 11'd2047);
    send_item(REQ_FIND, 11'd682);
    send_item(REQ_CLEAR, 11'd2047);

    // one word: out of range just past it
    write_words_in_use(1);
    send_item(REQ_SET, 11'd32);
    send_item(REQ_SET, 11'd31);
    send_item(REQ_CLEAR, 11'd31);

    run_phase(1, PHASE_ITEMS);
    run_phase(2, PHASE_ITEMS);
    run_phase(0, PHASE_ITEMS / 2);
    run_phase(127, PHASE_ITEMS);
    run_phase(3, PHASE_ITEMS);
    run_phase($urandom_range(63, 4), PHASE_ITEMS);
    run_phase(64, PHASE_ITEMS);
    run_phase(1, PHASE_ITEMS);
    run_phase(32, PHASE_ITEMS);

    drain();
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("bitmap_free_bit_allocator regression: pass");
    end else begin
      $display("bitmap_free_bit_allocator regression: fail");
    end
    $finish;
  end

endmodule

// ===== bitmap_free_bit_allocator.f =====
rtl/bfba_pkg.sv
rtl/bfba_ctrl.sv
rtl/bfba_dp.sv
rtl/bitmap_free_bit_allocator.sv
tb/tb_bitmap_free_bit_allocator.sv
